// ===== design/acfp_pkg.sv =====
// ----------------------------------------------------------------------------
// acfp_pkg
// shared types and constants for the ascii can frame parser
// ----------------------------------------------------------------------------
package acfp_pkg;

	localparam int MAX_DATA_BYTES_DEF = 8;
	localparam int NUM_DATA_BYTES     = 8;
	localparam int ID_DIGITS          = 3;

	localparam logic [7:0] START_BYTE = 8'h74;
	localparam logic [7:0] CR_BYTE    = 8'h0D;

	localparam logic FRAME_GOOD = 1'b0;
	localparam logic FRAME_DROP = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_ID   = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_CR   = 3'd4
	} phase_t;

	// decoded view of one received byte
	typedef struct packed {
		logic       is_start;
		logic       is_cr;
		logic       is_hex;
		logic [3:0] nibble;
	} byte_class_t;

	// one parsed frame result
	typedef struct packed {
		logic                                frame_status;
		logic [11:0]                         frame_id;
		logic [3:0]                          frame_length;
		logic [NUM_DATA_BYTES-1:0][7:0]      data;
	} frame_t;

endpackage

// ===== design/acfp_if.sv =====
// ----------------------------------------------------------------------------
// acfp channel interfaces
// valid/ready channels for received bytes and parsed frames
// ----------------------------------------------------------------------------
interface acfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface acfp_frame_if;
	logic        valid;
	logic        ready;
	logic        frame_status;
	logic [11:0] frame_id;
	logic [3:0]  frame_length;
	logic [7:0]  byte_zero;
	logic [7:0]  byte_one;
	logic [7:0]  byte_two;
	logic [7:0]  byte_three;
	logic [7:0]  byte_four;
	logic [7:0]  byte_five;
	logic [7:0]  byte_six;
	logic [7:0]  byte_seven;

	modport source (
		output valid, output frame_status, output frame_id, output frame_length,
		output byte_zero, output byte_one, output byte_two, output byte_three,
		output byte_four, output byte_five, output byte_six, output byte_seven,
		input ready
	);
	modport sink (
		input valid, input frame_status, input frame_id, input frame_length,
		input byte_zero, input byte_one, input byte_two, input byte_three,
		input byte_four, input byte_five, input byte_six, input byte_seven,
		output ready
	);
endinterface

// ===== design/acfp_byte_class.sv =====
// ----------------------------------------------------------------------------
// acfp_byte_class
// classifies a received byte as start, carriage return or hex digit
// ----------------------------------------------------------------------------
module acfp_byte_class (
	input  logic [7:0]                rx_byte,
	output acfp_pkg::byte_class_t     cls
);

	logic is_digit;
	logic is_upper;
	logic is_lower;

	assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
	assign is_upper = (rx_byte >= 8'h41) && (rx_byte <= 8'h46);
	assign is_lower = (rx_byte >= 8'h61) && (rx_byte <= 8'h66);

	always_comb begin
		cls.is_start = (rx_byte == acfp_pkg::START_BYTE);
		cls.is_cr    = (rx_byte == acfp_pkg::CR_BYTE);
		cls.is_hex   = is_digit || is_upper || is_lower;
		// letters a-f sit at low nibble 1..6 in both cases
		if (is_digit) begin
			cls.nibble = rx_byte[3:0];
		end else begin
			cls.nibble = rx_byte[3:0] + 4'd9;
		end
	end

endmodule

// ===== design/acfp_parse_core.sv =====
// ----------------------------------------------------------------------------
// acfp_parse_core
// frame parsing state and result formation, one byte per step
// ----------------------------------------------------------------------------
module acfp_parse_core #(
	parameter int MAX_DATA_BYTES = acfp_pkg::MAX_DATA_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  acfp_pkg::byte_class_t     cls,
	output logic                      emit,
	output acfp_pkg::frame_t          result
);

	localparam int CNT_W = $clog2(2 * MAX_DATA_BYTES + 1);
	localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
	localparam logic [4:0] MAX_LEN = 5'(MAX_DATA_BYTES);

	acfp_pkg::phase_t phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
	logic [11:0]      id_q, id_d;
	logic [3:0]       len_q, len_d;
	logic [3:0]       high_q, high_d;
	logic [7:0]       store_q [MAX_DATA_BYTES];
	logic [7:0]       store_d [MAX_DATA_BYTES];
	logic [IDX_W-1:0] wr_idx;
	logic             good;

	assign cnt_inc = cnt_q + 1'b1;
	assign wr_idx  = cnt_q[IDX_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= acfp_pkg::PH_HUNT;
			cnt_q   <= '0;
			id_q    <= '0;
			len_q   <= '0;
			high_q  <= '0;
			for (int i = 0; i < MAX_DATA_BYTES; i++) begin
				store_q[i] <= '0;
			end
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			id_q    <= id_d;
			len_q   <= len_d;
			high_q  <= high_d;
			store_q <= store_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		id_d    = id_q;
		len_d   = len_q;
		high_d  = high_q;
		store_d = store_q;
		emit    = 1'b0;
		good    = 1'b0;

		// a start byte opens a fresh frame from any phase
		if (cls.is_start) begin
			phase_d = acfp_pkg::PH_ID;
			cnt_d   = '0;
			id_d    = '0;
			len_d   = '0;
			high_d  = '0;
			for (int i = 0; i < MAX_DATA_BYTES; i++) begin
				store_d[i] = '0;
			end
		end

		unique case (phase_q)
			acfp_pkg::PH_HUNT: begin
			end
			acfp_pkg::PH_CR: begin
				emit = 1'b1;
				if (!cls.is_start) begin
					phase_d = acfp_pkg::PH_HUNT;
					good    = cls.is_cr;
				end
			end
			acfp_pkg::PH_ID, acfp_pkg::PH_LEN, acfp_pkg::PH_DATA: begin
				if (cls.is_start) begin
					emit = 1'b1;
				end else if (!cls.is_hex) begin
					emit    = 1'b1;
					phase_d = acfp_pkg::PH_HUNT;
				end else if (phase_q == acfp_pkg::PH_ID) begin
					id_d = {id_q[7:0], cls.nibble};
					if (cnt_inc >= CNT_W'(acfp_pkg::ID_DIGITS)) begin
						phase_d = acfp_pkg::PH_LEN;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_inc;
					end
				end else if (phase_q == acfp_pkg::PH_LEN) begin
					if ({1'b0, cls.nibble} > MAX_LEN) begin
						emit    = 1'b1;
						phase_d = acfp_pkg::PH_HUNT;
					end else begin
						len_d   = cls.nibble;
						cnt_d   = '0;
						phase_d = (cls.nibble == 4'd0) ? acfp_pkg::PH_CR
							: acfp_pkg::PH_DATA;
					end
				end else begin
					if (!cnt_q[0]) begin
						high_d = cls.nibble;
					end else begin
						store_d[wr_idx] = {high_q, cls.nibble};
					end
					cnt_d = cnt_inc;
					if (6'(cnt_inc) >= 6'({len_q, 1'b0})) begin
						phase_d = acfp_pkg::PH_CR;
					end
				end
			end
			default: begin
				phase_d = cls.is_start ? acfp_pkg::PH_ID : acfp_pkg::PH_HUNT;
			end
		endcase
	end

	// result payload, zero on a drop and beyond the frame length
	assign result.frame_status = good ? acfp_pkg::FRAME_GOOD : acfp_pkg::FRAME_DROP;
	assign result.frame_id     = good ? id_q : 12'd0;
	assign result.frame_length = good ? len_q : 4'd0;

	for (genvar k = 0; k < acfp_pkg::NUM_DATA_BYTES; k++) begin : g_data
		if (k < MAX_DATA_BYTES) begin : g_used
			assign result.data[k] = (good && (4'(k) < len_q)) ? store_q[k] : 8'd0;
		end else begin : g_unused
			assign result.data[k] = 8'd0;
		end
	end

endmodule

// ===== design/ascii_can_frame_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_can_frame_parser
// parses ascii can data frames ('t', id, length, data, carriage return)
// from a byte stream into one good or drop result per frame
// ----------------------------------------------------------------------------
//
//  channel | modport | direction | request carries
//  --------+---------+-----------+--------------------------------------------
//  rx      | sink    | in        | rx_byte
//  frame   | source  | out       | frame_status, frame_id, frame_length,
//          |         |           | byte_zero .. byte_seven
//
//  one byte per cycle while the result register is free or draining; the byte
//  that closes or drops a frame passes the input register, then the result
//  register, before its result appears; rate set by the single parse step
//  between the input and result registers; arst_n clears the parse state to
//  hunting and empties both registers; a held result stalls the input register
//  only while it is full; bytes that give no result still pass when the result register is free or draining
//
module ascii_can_frame_parser #(
	parameter int MAX_DATA_BYTES = acfp_pkg::MAX_DATA_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	acfp_rx_if.sink       rx,
	acfp_frame_if.source  frame
);

	// input register stage
	acfp_pkg::byte_class_t cls_now;
	acfp_pkg::byte_class_t cls_s1;
	logic                  valid_s1;

	// result register
	acfp_pkg::frame_t      res_now;
	acfp_pkg::frame_t      res_q;
	logic                  res_valid_q;

	logic out_free;
	logic advance;
	logic emit;

	// decode in front of the input register keeps the parse step short
	acfp_byte_class u_class (
		.rx_byte (rx.rx_byte),
		.cls     (cls_now)
	);

	assign out_free = !res_valid_q || frame.ready;
	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			cls_s1 <= cls_now;
		end
	end

	// parse state advances once per byte leaving the input register
	acfp_parse_core #(
		.MAX_DATA_BYTES (MAX_DATA_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cls    (cls_s1),
		.emit   (emit),
		.result (res_now)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_now;
		end
	end

	assign frame.valid        = res_valid_q;
	assign frame.frame_status = res_q.frame_status;
	assign frame.frame_id     = res_q.frame_id;
	assign frame.frame_length = res_q.frame_length;
	assign frame.byte_zero    = res_q.data[0];
	assign frame.byte_one     = res_q.data[1];
	assign frame.byte_two     = res_q.data[2];
	assign frame.byte_three   = res_q.data[3];
	assign frame.byte_four    = res_q.data[4];
	assign frame.byte_five    = res_q.data[5];
	assign frame.byte_six     = res_q.data[6];
	assign frame.byte_seven   = res_q.data[7];

`ifndef NO_ASSERTIONS
	// a drop result carries no identifier and no length
	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.frame_status == acfp_pkg::FRAME_DROP)) |->
		((res_q.frame_id == 12'd0) && (res_q.frame_length == 4'd0)))
		else $error("drop result with nonzero id or length");

	// a good frame never reports more bytes than the store holds
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.frame_status == acfp_pkg::FRAME_GOOD)) |->
		({1'b0, res_q.frame_length} <= 5'(MAX_DATA_BYTES)))
		else $error("good result length above limit");

	// a new result only comes from a byte held in the input register
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1))
		else $error("result without a byte in the input register");

	// an empty input register never stalls the input, even behind a pending result
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1) |-> rx.ready)
		else $error("input stalled with empty input register");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// byte-stream check of the ascii can frame parser: a short directed run of
// frame corner cases with canned results, then random frames with noise and
// damage; random results are checked against an in-bench model of the parser
// ----------------------------------------------------------------------------
module testbench;
	import acfp_pkg::*;

	localparam int MAX_LEN      = MAX_DATA_BYTES_DEF;
	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 1700;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_PCT     = 31;
	localparam int MAX_REPORTS  = 10;

	// canned results for the directed rows
	localparam frame_t NO_FRAME    = '0;
	localparam frame_t EMPTY_FRAME = '{frame_status: FRAME_GOOD, frame_id: 12'h000,
		frame_length: 4'd0, data: '0};
	localparam frame_t DROPPED     = '{frame_status: FRAME_DROP, frame_id: 12'h000,
		frame_length: 4'd0, data: '0};

	// one directed stimulus row: the byte, and where obvious the result it closes
	typedef struct {
		logic [7:0] octet;
		bit         typed;
		frame_t     want;
	} dir_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	acfp_rx_if    rx ();
	acfp_frame_if frame ();

	ascii_can_frame_parser #(
		.MAX_DATA_BYTES(MAX_LEN)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx),
		.frame (frame)
	);

	always #HALF_PERIOD clk = ~clk;

	// directed part: skipped bytes at both extremes, an empty good frame, an
	// oversize length, a start byte mid-frame, a missing carriage return and
	// a carriage return that comes before the data
	dir_row_t dir_tab [28] = '{
		'{8'h00,      1'b0, NO_FRAME},      // noise while hunting
		'{8'hFF,      1'b0, NO_FRAME},
		'{START_BYTE, 1'b0, NO_FRAME},
		'{"0",        1'b0, NO_FRAME},
		'{"0",        1'b0, NO_FRAME},
		'{"0",        1'b0, NO_FRAME},
		'{"0",        1'b0, NO_FRAME},      // length zero goes straight to cr
		'{CR_BYTE,    1'b1, EMPTY_FRAME},
		'{START_BYTE, 1'b0, NO_FRAME},
		'{"F",        1'b0, NO_FRAME},
		'{"f",        1'b0, NO_FRAME},
		'{"F",        1'b0, NO_FRAME},
		'{"9",        1'b1, DROPPED},       // length above the maximum
		'{START_BYTE, 1'b0, NO_FRAME},
		'{"a",        1'b0, NO_FRAME},
		'{"b",        1'b0, NO_FRAME},
		'{START_BYTE, 1'b1, DROPPED},       // restart inside the identifier
		'{"c",        1'b0, NO_FRAME},
		'{"D",        1'b0, NO_FRAME},
		'{"e",        1'b0, NO_FRAME},
		'{"0",        1'b0, NO_FRAME},
		'{8'hFF,      1'b1, DROPPED},       // no carriage return
		'{START_BYTE, 1'b0, NO_FRAME},
		'{"1",        1'b0, NO_FRAME},
		'{"2",        1'b0, NO_FRAME},
		'{"3",        1'b0, NO_FRAME},
		'{"1",        1'b0, NO_FRAME},
		'{CR_BYTE,    1'b1, DROPPED}        // carriage return before the data
	};

	// in-bench copy of the parser state
	phase_t     ph       = PH_HUNT;
	logic [4:0] dig_cnt  = '0;
	logic [11:0] id_acc  = '0;
	logic [3:0] len_acc  = '0;
	logic [3:0] hi_nib   = '0;
	logic [7:0] data_acc [NUM_DATA_BYTES] = '{default: '0};

	frame_t     pending_frames [$];     // results still owed by the parser
	logic [7:0] burst [$];              // bytes of the next random frame
	int         fault_count = 0;
	int         sent_count  = 0;        // requests taken by the parser
	bit         calm        = 1'b0;     // no idling on either side

	function automatic bit hex_nibble(input logic [7:0] b, output logic [3:0] v);
		v = '0;
		if (b >= "0" && b <= "9") begin
			v = b[3:0];
			return 1'b1;
		end
		if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f")) begin
			v = b[3:0] + 4'd9;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void open_frame();
		ph      = PH_ID;
		dig_cnt = '0;
		id_acc  = '0;
		len_acc = '0;
		hi_nib  = '0;
		foreach (data_acc[k])
			data_acc[k] = '0;
	endfunction

	// advance the parser copy by one byte; tells whether a frame result
	// comes out
	function automatic void step_parser(input logic [7:0] b, output bit has_res,
		output frame_t res);
		logic [3:0] v;
		bit         is_hex;
		is_hex  = hex_nibble(b, v);
		has_res = 1'b0;
		res     = '0;
		if (ph == PH_HUNT) begin
			if (b == START_BYTE)
				open_frame();
			return;
		end
		// a start byte anywhere inside a frame drops it and opens a new one
		if (b == START_BYTE) begin
			open_frame();
			has_res          = 1'b1;
			res.frame_status = FRAME_DROP;
			return;
		end
		if (ph == PH_CR) begin
			ph      = PH_HUNT;
			has_res = 1'b1;
			if (b == CR_BYTE) begin
				res.frame_status = FRAME_GOOD;
				res.frame_id     = id_acc;
				res.frame_length = len_acc;
				for (int k = 0; k < NUM_DATA_BYTES; k++)
					res.data[k] = (k < len_acc) ? data_acc[k] : 8'h00;
			end else begin
				res.frame_status = FRAME_DROP;
			end
			return;
		end
		// identifier, length and data phases take hex digits only
		if (!is_hex) begin
			ph               = PH_HUNT;
			has_res          = 1'b1;
			res.frame_status = FRAME_DROP;
			return;
		end
		case (ph)
			PH_ID: begin
				id_acc  = {id_acc[7:0], v};
				dig_cnt = dig_cnt + 5'd1;
				if (dig_cnt >= ID_DIGITS) begin
					ph      = PH_LEN;
					dig_cnt = '0;
				end
			end
			PH_LEN: begin
				if (v > MAX_LEN) begin
					ph               = PH_HUNT;
					has_res          = 1'b1;
					res.frame_status = FRAME_DROP;
				end else begin
					len_acc = v;
					dig_cnt = '0;
					ph      = (v == 4'd0) ? PH_CR : PH_DATA;
				end
			end
			default: begin
				// data digits, high nibble first
				if (!dig_cnt[0])
					hi_nib = v;
				else
					data_acc[dig_cnt[3:1]] = {hi_nib, v};
				dig_cnt = dig_cnt + 5'd1;
				if (dig_cnt >= {len_acc, 1'b0})
					ph = PH_CR;
			end
		endcase
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return "0" + v;
		return ($urandom_range(0, 1) ? "A" : "a") + v - 8'd10;
	endfunction

	// one random frame into burst: mostly well formed with random content,
	// some with a bad length, some damaged, and a little line noise
	function automatic void build_frame();
		int         n;
		int         mode;
		int         pos;
		logic [3:0] len;
		burst.delete();
		mode = $urandom_range(0, 99);
		if (mode < 8) begin
			n = $urandom_range(1, 4);
			repeat (n)
				burst.push_back(8'($urandom_range(0, 255)));
			return;
		end
		burst.push_back(START_BYTE);
		repeat (ID_DIGITS)
			burst.push_back(hex_char(4'($urandom)));
		len = ($urandom_range(0, 99) < 6) ? 4'($urandom_range(MAX_LEN + 1, 15))
			: 4'($urandom_range(0, MAX_LEN));
		burst.push_back(hex_char(len));
		if (len <= MAX_LEN)
			repeat (2 * len)
				burst.push_back(hex_char(4'($urandom)));
		burst.push_back(CR_BYTE);
		if (mode >= 78) begin
			pos = $urandom_range(1, burst.size() - 1);
			case (mode % 3)
				0: burst[pos] = 8'($urandom_range(0, 255));     // garbled byte
				1: while (burst.size() > pos)                   // cut short
					void'(burst.pop_back());
				default: burst.insert(pos, CR_BYTE);            // stray cr
			endcase
		end
	endfunction

	// offer one byte, with random idle cycles ahead of it, and book the
	// result it closes once the request is taken
	task automatic send_byte(input logic [7:0] b, input bit typed, input frame_t want);
		bit     has_res;
		frame_t res;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx.ready);
		step_parser(b, has_res, res);
		if (typed) begin
			has_res = 1'b1;
			res     = want;
		end
		if (has_res)
			pending_frames.push_back(res);
		sent_count++;
	endtask

	task automatic check_frame();
		frame_t got;
		frame_t want;
		bit     bad;
		got.frame_status = frame.frame_status;
		got.frame_id     = frame.frame_id;
		got.frame_length = frame.frame_length;
		got.data[0]      = frame.byte_zero;
		got.data[1]      = frame.byte_one;
		got.data[2]      = frame.byte_two;
		got.data[3]      = frame.byte_three;
		got.data[4]      = frame.byte_four;
		got.data[5]      = frame.byte_five;
		got.data[6]      = frame.byte_six;
		got.data[7]      = frame.byte_seven;
		if (pending_frames.size() == 0) begin
			if (fault_count < MAX_REPORTS)
				$display("%0t: unexpected frame status %0d id %h len %0d data %h",
					$realtime, got.frame_status, got.frame_id, got.frame_length, got.data);
			fault_count++;
			return;
		end
		want = pending_frames.pop_front();
		bad  = (got.frame_status !== want.frame_status) || (got.frame_id !== want.frame_id)
			|| (got.frame_length !== want.frame_length);
		for (int k = 0; k < NUM_DATA_BYTES; k++)
			bad |= (got.data[k] !== want.data[k]);
		if (bad) begin
			if (fault_count < MAX_REPORTS)
				$display("%0t: frame want st %0d id %h len %0d data %h / got st %0d id %h len %0d data %h",
					$realtime, want.frame_status, want.frame_id, want.frame_length, want.data,
					got.frame_status, got.frame_id, got.frame_length, got.data);
			fault_count++;
		end
	endtask

	// frame side: take results at the edge, then pick ready for the next cycle
	initial begin
		frame.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && frame.valid && frame.ready)
				check_frame();
			frame.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// byte side
	initial begin
		int base;
		rx.valid   <= 1'b0;
		rx.rx_byte <= '0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_byte(dir_tab[i].octet, dir_tab[i].typed, dir_tab[i].want);

		// hold off until the parser has handed back every frame
		rx.valid <= 1'b0;
		@(posedge clk);
		while (pending_frames.size() != 0)
			@(posedge clk);

		// random frames; a stretch in the middle runs with no idling
		base = sent_count;
		while (sent_count - base < RANDOM_ITEMS) begin
			calm = (sent_count - base >= 700) && (sent_count - base < 1000);
			build_frame();
			foreach (burst[k])
				send_byte(burst[k], 1'b0, NO_FRAME);
		end
		calm = 1'b0;
		rx.valid <= 1'b0;

		// drain, then give the result register time to show anything stray
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
